/* sv/sfld_pkg.sv */
// Shared types, codes and constants for the fixed-length SLIP receive deframer.
package sfld_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 8;
    localparam int TICK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item function codes
    localparam logic [FUNC_W-1:0] FN_START = 2'd0;
    localparam logic [FUNC_W-1:0] FN_BYTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TICK  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DATA    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd3;

    // Receive phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ESCAPE  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CLOSE   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BYTE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP_LIMIT   = 2'd2;

    // Configuration reset values
    localparam logic [LEN_W-1:0]  RST_PAYLOAD_LENGTH   = 8'd1;
    localparam logic [TICK_W-1:0] RST_FIRST_BYTE_LIMIT = 16'd1000;
    localparam logic [TICK_W-1:0] RST_BYTE_GAP_LIMIT   = 16'd100;

    // SLIP special bytes
    localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

    typedef struct packed {
        logic [LEN_W-1:0]  payload_length;
        logic [TICK_W-1:0] first_byte_limit;
        logic [TICK_W-1:0] byte_gap_limit;
    } t_cfg;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEN_W-1:0]   bytes_done;
        logic [TICK_W-1:0]  wait_ticks;
    } t_state;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data_byte;
        logic [LEN_W-1:0]    byte_index;
    } t_result;

endpackage

/* sv/sfld_step.sv */
// Next-state and result logic of the deframer for one input beat.
module sfld_step (
    input  sfld_pkg::t_cfg                    i_cfg,
    input  sfld_pkg::t_state                  i_state,
    input  logic [sfld_pkg::FUNC_W-1:0]       i_func,
    input  logic [sfld_pkg::BYTE_W-1:0]       i_rx_byte,
    output sfld_pkg::t_state                  o_state,
    output sfld_pkg::t_result                 o_result
);
    import sfld_pkg::*;

    logic [TICK_W:0]     wait_inc;
    logic [TICK_W-1:0]   limit;
    logic [LEN_W-1:0]    bytes_inc;
    logic                deliver;
    logic [BYTE_W-1:0]   deliver_val;

    assign wait_inc  = {1'b0, i_state.wait_ticks} + {{TICK_W{1'b0}}, 1'b1};
    assign bytes_inc = i_state.bytes_done + {{(LEN_W-1){1'b0}}, 1'b1};
    // Before the opening byte the response limit applies, later the gap limit
    assign limit     = (i_state.phase == PH_OPEN) ? i_cfg.first_byte_limit
                                                  : i_cfg.byte_gap_limit;

    always_comb begin
        o_state     = i_state;
        o_result    = '0;
        deliver     = 1'b0;
        deliver_val = '0;

        if (i_func == FN_START) begin
            // (Re-)arm; any frame in progress is dropped
            o_state.phase      = PH_OPEN;
            o_state.bytes_done = '0;
            o_state.wait_ticks = '0;
        end else if (i_state.phase != PH_IDLE) begin
            unique case (i_func)
                FN_TICK: begin
                    o_state.wait_ticks = wait_inc[TICK_W-1:0];
                    if (wait_inc >= {1'b0, limit}) begin
                        o_state.phase      = PH_IDLE;
                        o_state.wait_ticks = '0;
                        o_result.found     = 1'b1;
                        o_result.status    = ST_TIMEOUT;
                    end
                end
                FN_BYTE: begin
                    o_state.wait_ticks = '0;
                    unique case (i_state.phase)
                        PH_OPEN: begin
                            // Opening delimiter, not checked
                            o_state.bytes_done = '0;
                            o_state.phase = (i_cfg.payload_length == '0) ? PH_CLOSE
                                                                         : PH_PAYLOAD;
                        end
                        PH_PAYLOAD: begin
                            if (i_rx_byte == SLIP_ESC) begin
                                o_state.phase = PH_ESCAPE;
                            end else begin
                                deliver     = 1'b1;
                                deliver_val = i_rx_byte;
                            end
                        end
                        PH_ESCAPE: begin
                            if (i_rx_byte == SLIP_ESC_END) begin
                                deliver     = 1'b1;
                                deliver_val = SLIP_END;
                            end else if (i_rx_byte == SLIP_ESC_ESC) begin
                                deliver     = 1'b1;
                                deliver_val = SLIP_ESC;
                            end else begin
                                o_state.phase   = PH_IDLE;
                                o_result.found  = 1'b1;
                                o_result.status = ST_CORRUPT;
                            end
                        end
                        PH_CLOSE: begin
                            // Closing delimiter, not checked
                            o_state.phase   = PH_IDLE;
                            o_result.found  = 1'b1;
                            o_result.status = ST_DONE;
                        end
                        default: begin
                            o_state.phase = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        // Hand out one decoded payload byte
        if (deliver) begin
            o_result.found      = 1'b1;
            o_result.status     = ST_DATA;
            o_result.data_byte  = deliver_val;
            o_result.byte_index = i_state.bytes_done;
            o_state.bytes_done  = bytes_inc;
            o_state.phase = (bytes_inc >= i_cfg.payload_length) ? PH_CLOSE : PH_PAYLOAD;
        end
    end

endmodule

/* sv/slip_fixed_length_deframer.sv */
// Fixed-length SLIP receive deframer, top level.
//
// Input channel (i_in_valid / o_in_stall) carries one beat per start, received
// byte or timer tick, selected by i_func. A start arms the block; the first byte
// is the opening delimiter, then payload_length decoded bytes come out with
// status data, then the closing byte gives status done. A bad escape gives
// status corrupt; reaching a tick limit gives status timeout. Starts, escapes,
// delimiters without result, and beats while idle give no result.
// Output channel (o_out_valid / i_out_stall) carries status, byte and index.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes registers at any time
// and is always ready; index 3 is ignored.
// A beat taken into the input register is decoded combinationally from it and,
// once it can advance, its result, if any, is loaded into the output register.
// Throughput: one beat per cycle while the receiver does not stall the output.
// When the receiver stalls, the result holds and at most one further beat is
// still taken into the input register before o_in_stall rises.
// Reset clears the registers to their defaults, the phase to idle and both
// channel registers to empty.
module slip_fixed_length_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sfld_pkg::FUNC_W-1:0]         i_func,
    input  logic [sfld_pkg::BYTE_W-1:0]         i_rx_byte,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sfld_pkg::STATUS_W-1:0]       o_status,
    output logic [sfld_pkg::BYTE_W-1:0]         o_data_byte,
    output logic [sfld_pkg::LEN_W-1:0]          o_byte_index,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfld_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sfld_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sfld_pkg::*;

    t_cfg                r_cfg;
    t_state              r_state;
    t_state              n_state;
    t_result             n_result;
    t_result             r_out;
    logic                r_out_valid;
    logic                r_in_valid;
    logic [FUNC_W-1:0]   r_in_func;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                advance;
    logic                in_take;

    // Pipeline control
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_length   <= RST_PAYLOAD_LENGTH;
            r_cfg.first_byte_limit <= RST_FIRST_BYTE_LIMIT;
            r_cfg.byte_gap_limit   <= RST_BYTE_GAP_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PAYLOAD_LENGTH:   r_cfg.payload_length   <= i_cfg_data[LEN_W-1:0];
                REG_FIRST_BYTE_LIMIT: r_cfg.first_byte_limit <= i_cfg_data[TICK_W-1:0];
                REG_BYTE_GAP_LIMIT:   r_cfg.byte_gap_limit   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func <= i_func;
            r_in_byte <= i_rx_byte;
        end
    end

    // Decode step
    sfld_step u_step (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_func    (r_in_func),
        .i_rx_byte (r_in_byte),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // Deframer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_IDLE;
            r_state.bytes_done <= '0;
            r_state.wait_ticks <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_result.found) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.found) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_data_byte  = r_out.data_byte;
    assign o_byte_index = r_out.byte_index;

    // Checks
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= PH_CLOSE)
        else $error("deframer phase out of range");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DATA |-> o_data_byte == '0 && o_byte_index == '0)
        else $error("non-data result carries byte or index");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.found && n_result.status != ST_DATA
        |=> r_state.phase == PH_IDLE)
        else $error("frame end did not return to idle");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with nothing pending");

    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.found |=> o_out_valid)
        else $error("decoded result dropped");

endmodule
